>>> hdl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// shared types, token codes and character classes for the stream tokenizer
// ----------------------------------------------------------------------------
`default_nettype none

package cst_pkg;

    localparam int MAX_LEXEME    = 63;
    localparam int RUN_W         = $clog2(MAX_LEXEME + 2);
    localparam int TOKEN_LEN_TOP = 63;
    localparam int LEN_CAP       = (MAX_LEXEME < TOKEN_LEN_TOP) ? MAX_LEXEME : TOKEN_LEN_TOP;
    localparam int KEYWORD_LEN   = 5;

    localparam logic [3:0] KIND_INT     = 4'd0;
    localparam logic [3:0] KIND_IDENT   = 4'd1;
    localparam logic [3:0] KIND_PRINT   = 4'd2;
    localparam logic [3:0] KIND_ASSIGN  = 4'd3;
    localparam logic [3:0] KIND_PLUS    = 4'd4;
    localparam logic [3:0] KIND_MINUS   = 4'd5;
    localparam logic [3:0] KIND_LPAREN  = 4'd6;
    localparam logic [3:0] KIND_RPAREN  = 4'd7;
    localparam logic [3:0] KIND_EOL     = 4'd8;
    localparam logic [3:0] KIND_EOF     = 4'd9;
    localparam logic [3:0] KIND_UNKNOWN = 4'd10;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_EQUAL   = 8'h3D;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;
    localparam logic [7:0] CHAR_LPAREN  = 8'h28;
    localparam logic [7:0] CHAR_RPAREN  = 8'h29;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_INT   = 2'd1,
        MODE_IDENT = 2'd2
    } run_mode_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [5:0] length;
        logic       truncated;
        logic       last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    // letters of the keyword "print"
    function automatic logic [7:0] keyword_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h70;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] symbol_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CHAR_EQUAL:   k = KIND_ASSIGN;
            CHAR_PLUS:    k = KIND_PLUS;
            CHAR_MINUS:   k = KIND_MINUS;
            CHAR_LPAREN:  k = KIND_LPAREN;
            CHAR_RPAREN:  k = KIND_RPAREN;
            CHAR_NEWLINE: k = KIND_EOL;
            default:      k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

>>> hdl/char_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// character-serial lexer: one character per request, integer, identifier,
// keyword and symbol tokens out
// ----------------------------------------------------------------------------
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | in_valid/in_ready  | char_code, end_of_input
//  output   | out_valid/out_ready| token_kind, token_length, truncated,
//           |                    | last_of_item
//
//  a request is registered on acceptance and classified from the input register
//  once the queue has room; its tokens are registered into the token queue
//  one request per cycle is sustained while out_ready is high and each gives at
//  most one token; a request that closes a run and adds a symbol or eof gives
//  two tokens, which leave one after the other through the single output port
//  the token queue holds three entries; a request leaves the input register
//  only when two free entries are certain, so out_ready low can stall the input
//  reset clears the run state, the input register valid and the queue count
//
`default_nettype none

module char_stream_tokenizer (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_code,
    input  wire logic       end_of_input,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [3:0]      token_kind,
    output logic [5:0]      token_length,
    output logic            truncated,
    output logic            last_of_item
);

    import cst_pkg::*;

    localparam int QUEUE_DEPTH = 3;

    // input register
    logic       s1_valid_reg;
    logic [7:0] s1_char_reg;
    logic       s1_eoi_reg;

    // run state
    run_mode_t        mode_reg,   mode_next;
    logic [RUN_W-1:0] len_reg,    len_next;
    logic             alive_reg,  alive_next;

    // result queue, entry 0 is the head
    token_t     queue_reg [QUEUE_DEPTH];
    token_t     queue_next [QUEUE_DEPTH];
    logic [1:0] count_reg, count_next;

    logic   pop;
    logic   s1_go;
    logic   in_take;

    // tokens produced by the request in the input register
    token_t     tok0, tok1;
    logic [1:0] tok_count;

    token_t     run_tok;
    logic       run_open;
    logic       run_trunc;
    logic [1:0] base;

    assign pop      = out_valid && out_ready;
    // room for two tokens after this cycle's pop
    assign s1_go    = s1_valid_reg && ((count_reg <= 2'd1) || ((count_reg == 2'd2) && pop));
    assign in_ready = !s1_valid_reg || s1_go;
    assign in_take  = in_valid && in_ready;

    assign out_valid    = (count_reg != 2'd0);
    assign token_kind   = queue_reg[0].kind;
    assign token_length = queue_reg[0].length;
    assign truncated    = queue_reg[0].truncated;
    assign last_of_item = queue_reg[0].last;

    // token for the run that is open, if it closes now
    always_comb
    begin
        run_open  = (mode_reg != MODE_IDLE);
        run_trunc = (int'(len_reg) > MAX_LEXEME);
        run_tok.truncated = run_trunc;
        run_tok.last      = 1'b0;
        if (run_trunc)
            run_tok.length = 6'(LEN_CAP);
        else if (int'(len_reg) > TOKEN_LEN_TOP)
            run_tok.length = 6'(TOKEN_LEN_TOP);
        else
            run_tok.length = 6'(len_reg);
        if (mode_reg == MODE_INT)
            run_tok.kind = KIND_INT;
        else if (alive_reg && (int'(len_reg) == KEYWORD_LEN))
            run_tok.kind = KIND_PRINT;
        else
            run_tok.kind = KIND_IDENT;
    end

    // classification and next run state
    always_comb
    begin
        token_t sym_tok;
        logic   extend;
        logic   has_sym;

        mode_next  = mode_reg;
        len_next   = len_reg;
        alive_next = alive_reg;

        sym_tok.kind      = symbol_kind(s1_char_reg);
        sym_tok.length    = (s1_char_reg == CHAR_NEWLINE) ? 6'd0 : 6'd1;
        sym_tok.truncated = 1'b0;
        sym_tok.last      = 1'b0;

        extend  = 1'b0;
        has_sym = 1'b0;

        if (s1_eoi_reg)
        begin
            sym_tok.kind   = KIND_EOF;
            sym_tok.length = 6'd0;
            has_sym        = 1'b1;
            mode_next      = MODE_IDLE;
            len_next       = '0;
            alive_next     = 1'b1;
        end
        else if (((mode_reg == MODE_INT) && is_digit(s1_char_reg)) ||
                 ((mode_reg == MODE_IDENT) &&
                  (is_digit(s1_char_reg) || is_letter(s1_char_reg))))
        begin
            extend = 1'b1;
            // keyword match tracks only the first five characters
            if (int'(len_reg) < KEYWORD_LEN)
                alive_next = alive_reg && (s1_char_reg == keyword_char(len_reg[2:0]));
            else
                alive_next = 1'b0;
            if (int'(len_reg) <= MAX_LEXEME)
                len_next = len_reg + RUN_W'(1);
        end
        else
        begin
            mode_next  = MODE_IDLE;
            len_next   = '0;
            alive_next = 1'b1;
            if ((s1_char_reg == CHAR_SPACE) || (s1_char_reg == CHAR_TAB))
            begin
                // whitespace, nothing more
            end
            else if (is_digit(s1_char_reg) || is_letter(s1_char_reg))
            begin
                mode_next  = is_digit(s1_char_reg) ? MODE_INT : MODE_IDENT;
                len_next   = RUN_W'(1);
                alive_next = (s1_char_reg == keyword_char(3'd0));
            end
            else
            begin
                has_sym = 1'b1;
            end
        end

        // order: closed run first, then the symbol or eof
        tok0 = sym_tok;
        tok1 = sym_tok;
        if (extend)
            tok_count = 2'd0;
        else if (run_open)
        begin
            tok0      = run_tok;
            tok_count = has_sym ? 2'd2 : 2'd1;
        end
        else
            tok_count = has_sym ? 2'd1 : 2'd0;

        if (tok_count == 2'd2)
            tok1.last = 1'b1;
        else
            tok0.last = 1'b1;
    end

    // queue shift on pop, append new tokens behind the survivors
    always_comb
    begin
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (pop && (i < QUEUE_DEPTH - 1))
                queue_next[i] = queue_reg[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            else
                queue_next[i] = queue_reg[i];
            if (s1_go && (tok_count != 2'd0) && (2'(i) == base))
                queue_next[i] = tok0;
            if (s1_go && (tok_count == 2'd2) && (2'(i) == base + 2'd1))
                queue_next[i] = tok1;
        end
        count_next = base;
        if (s1_go)
            count_next = base + tok_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            mode_reg     <= MODE_IDLE;
            len_reg      <= '0;
            alive_reg    <= 1'b1;
            count_reg    <= 2'd0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_go)
                s1_valid_reg <= 1'b0;
            if (s1_go)
            begin
                mode_reg  <= mode_next;
                len_reg   <= len_next;
                alive_reg <= alive_next;
            end
            count_reg <= count_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_char_reg <= char_code;
            s1_eoi_reg  <= end_of_input;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++)
            queue_reg[i] <= queue_next[i];
    end

endmodule

`default_nettype wire

>>> tb/char_stream_tokenizer_test.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer_test
// self-checking bench for the character-serial tokenizer: a short table of
// hand-picked characters, then about two thousand characters of random source
// text, every token checked field by field against typed tokens or a software lexer
// ----------------------------------------------------------------------------
`default_nettype none

module char_stream_tokenizer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    // one request as the sender offers it; typed rows carry their own tokens
    typedef struct packed {
        logic [7:0] ch;
        logic       eoi;
        logic       typed;
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } request_t;

    localparam int          RANDOM_CHARS = 2000;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          HOLD_START   = 1500;
    localparam int          HOLD_CYCLES  = 250;
    localparam logic [39:0] PRINT_TEXT   = "print";
    localparam token_t      NO_TOKEN     = '0;

    // directed table: tokens typed in where the answer is obvious, the rest
    // goes through the software lexer
    localparam int DIRECTED_ROWS = 22;
    localparam request_t DIRECTED [DIRECTED_ROWS] = '{
        // end mark straight after reset
        '{8'h00, 1'b1, 1'b1, 2'd1, '{KIND_EOF, 6'd0, 1'b0, 1'b1}, NO_TOKEN},
        // byte extremes are unknown characters
        '{8'h00, 1'b0, 1'b1, 2'd1, '{KIND_UNKNOWN, 6'd1, 1'b0, 1'b1}, NO_TOKEN},
        '{8'hFF, 1'b0, 1'b1, 2'd1, '{KIND_UNKNOWN, 6'd1, 1'b0, 1'b1}, NO_TOKEN},
        // every symbol
        '{CHAR_EQUAL, 1'b0, 1'b1, 2'd1, '{KIND_ASSIGN, 6'd1, 1'b0, 1'b1}, NO_TOKEN},
        '{CHAR_PLUS, 1'b0, 1'b1, 2'd1, '{KIND_PLUS, 6'd1, 1'b0, 1'b1}, NO_TOKEN},
        '{CHAR_MINUS, 1'b0, 1'b1, 2'd1, '{KIND_MINUS, 6'd1, 1'b0, 1'b1}, NO_TOKEN},
        '{CHAR_LPAREN, 1'b0, 1'b1, 2'd1, '{KIND_LPAREN, 6'd1, 1'b0, 1'b1}, NO_TOKEN},
        '{CHAR_RPAREN, 1'b0, 1'b1, 2'd1, '{KIND_RPAREN, 6'd1, 1'b0, 1'b1}, NO_TOKEN},
        '{CHAR_NEWLINE, 1'b0, 1'b1, 2'd1, '{KIND_EOL, 6'd0, 1'b0, 1'b1}, NO_TOKEN},
        // whitespace gives nothing
        '{CHAR_TAB, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{CHAR_SPACE, 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        // keyword closed by a paren: two tokens from one request
        '{"p", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{"r", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{"i", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{"n", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{"t", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{CHAR_LPAREN, 1'b0, 1'b1, 2'd2, '{KIND_PRINT, 6'd5, 1'b0, 1'b0},
          '{KIND_LPAREN, 6'd1, 1'b0, 1'b1}},
        // letter right after digits, then an end mark closing an open run
        '{"9", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{"0", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{"x", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{"Z", 1'b0, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN},
        '{8'h41, 1'b1, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN}
    };

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [7:0] char_code    = 8'h00;
    logic       end_of_input = 1'b0;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic [3:0] token_kind;
    logic [5:0] token_length;
    logic       truncated;
    logic       last_of_item;

    // request currently on the input, with its typed tokens if any
    request_t   offered = '0;

    // software lexer state
    run_mode_t  lex_mode     = MODE_IDLE;
    int         lex_run_len  = 0;
    logic       lex_kw_alive = 1'b1;

    token_t     pending_tokens [$];
    request_t   script [$];

    int         mismatch_count     = 0;
    int         requests_taken     = 0;
    int         tokens_checked     = 0;
    int         keyword_tokens     = 0;
    int         overlong_tokens    = 0;
    int         input_stall_cycles = 0;

    char_stream_tokenizer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .token_length (token_length),
        .truncated    (truncated),
        .last_of_item (last_of_item)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // software lexer
    // ------------------------------------------------------------------------

    function automatic logic is_num_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // i-th letter of the keyword
    function automatic logic [7:0] keyword_letter(input int i);
        return 8'(PRINT_TEXT >> (8 * (4 - i)));
    endfunction

    // add one character to the open run, tracking the keyword prefix
    function automatic void grow_run(input logic [7:0] c);
        if (lex_run_len >= KEYWORD_LEN || c != keyword_letter(lex_run_len))
            lex_kw_alive = 1'b0;
        // count stops one past the limit so overlong runs stay visible
        if (lex_run_len <= MAX_LEXEME)
            lex_run_len++;
    endfunction

    // token for the open run; leaves the lexer idle
    function automatic token_t close_run();
        token_t tok;
        int     len;
        len = lex_run_len;
        if (len > LEN_CAP)
            len = LEN_CAP;
        tok.length    = len[5:0];
        tok.truncated = lex_run_len > MAX_LEXEME;
        tok.last      = 1'b0;
        if (lex_mode == MODE_INT)
            tok.kind = KIND_INT;
        else if (lex_kw_alive && lex_run_len == KEYWORD_LEN)
            tok.kind = KIND_PRINT;
        else
            tok.kind = KIND_IDENT;
        lex_mode     = MODE_IDLE;
        lex_run_len  = 0;
        lex_kw_alive = 1'b1;
        return tok;
    endfunction

    // tokens caused by one request, returned in toks, which is cleared first
    function automatic void lex_step(input logic [7:0] c, input logic eoi,
                                     ref token_t toks [$]);
        logic [3:0] kind;
        toks.delete();
        if (eoi) begin
            if (lex_mode != MODE_IDLE)
                toks.push_back(close_run());
            toks.push_back(token_t'{KIND_EOF, 6'd0, 1'b0, 1'b0});
        end else if ((lex_mode == MODE_INT && is_num_char(c)) ||
                     (lex_mode == MODE_IDENT && (is_num_char(c) || is_alpha_char(c)))) begin
            grow_run(c);
        end else begin
            if (lex_mode != MODE_IDLE)
                toks.push_back(close_run());
            if (c == CHAR_SPACE || c == CHAR_TAB) begin
                // whitespace only separates
            end else if (is_num_char(c) || is_alpha_char(c)) begin
                lex_mode     = is_num_char(c) ? MODE_INT : MODE_IDENT;
                lex_run_len  = 0;
                lex_kw_alive = 1'b1;
                grow_run(c);
            end else begin
                case (c)
                    CHAR_EQUAL:   kind = KIND_ASSIGN;
                    CHAR_PLUS:    kind = KIND_PLUS;
                    CHAR_MINUS:   kind = KIND_MINUS;
                    CHAR_LPAREN:  kind = KIND_LPAREN;
                    CHAR_RPAREN:  kind = KIND_RPAREN;
                    CHAR_NEWLINE: kind = KIND_EOL;
                    default:      kind = KIND_UNKNOWN;
                endcase
                toks.push_back(token_t'{kind, (kind == KIND_EOL) ? 6'd0 : 6'd1,
                                        1'b0, 1'b0});
            end
        end
        if (toks.size() > 0)
            toks[toks.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // random source text
    // ------------------------------------------------------------------------

    function automatic void add_char(input logic [7:0] c, input logic eoi);
        script.push_back(request_t'{c, eoi, 1'b0, 2'd0, NO_TOKEN, NO_TOKEN});
    endfunction

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // ------------------------------------------------------------------------
    // sender: reset, then the directed table and the random text in bursts
    // ------------------------------------------------------------------------
    initial
    begin : sender
        int piece;
        int len;
        int k;
        int burst_left;
        int gap;
        logic [7:0] c;

        foreach (DIRECTED[i])
            script.push_back(DIRECTED[i]);

        while (script.size() < DIRECTED_ROWS + RANDOM_CHARS) begin
            piece = $urandom_range(0, 99);
            if (piece < 26) begin
                // identifiers, with the keyword and its near misses well represented
                case ($urandom_range(0, 5))
                    0: for (k = 0; k < KEYWORD_LEN; k++) add_char(keyword_letter(k), 1'b0);
                    1: begin
                        for (k = 0; k < KEYWORD_LEN; k++) add_char(keyword_letter(k), 1'b0);
                        add_char(($urandom_range(0, 1) != 0) ? rand_letter() : rand_digit(),
                                 1'b0);
                    end
                    2: begin
                        len = $urandom_range(1, KEYWORD_LEN - 1);
                        for (k = 0; k < len; k++) add_char(keyword_letter(k), 1'b0);
                    end
                    3: begin
                        // keyword with one letter swapped
                        len = $urandom_range(0, KEYWORD_LEN - 1);
                        for (k = 0; k < KEYWORD_LEN; k++)
                            add_char((k == len) ? rand_letter() : keyword_letter(k), 1'b0);
                    end
                    default: begin
                        add_char(rand_letter(), 1'b0);
                        len = $urandom_range(0, 7);
                        for (k = 0; k < len; k++)
                            add_char(($urandom_range(0, 2) != 0) ? rand_letter() : rand_digit(),
                                     1'b0);
                    end
                endcase
                if ($urandom_range(0, 9) < 6)
                    add_char(CHAR_SPACE, 1'b0);
            end else if (piece < 46) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) add_char(rand_digit(), 1'b0);
                if ($urandom_range(0, 9) < 6)
                    add_char(CHAR_SPACE, 1'b0);
            end else if (piece < 47) begin
                // overlong run, mostly around the length limit
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(MAX_LEXEME + 1, 100)
                                                  : $urandom_range(MAX_LEXEME - 2,
                                                                   MAX_LEXEME + 3);
                c = ($urandom_range(0, 1) != 0) ? rand_letter() : rand_digit();
                add_char(c, 1'b0);
                for (k = 1; k < len; k++)
                    add_char(is_num_char(c) ? rand_digit() : rand_letter(), 1'b0);
            end else if (piece < 73) begin
                case ($urandom_range(0, 5))
                    0:       add_char(CHAR_EQUAL, 1'b0);
                    1:       add_char(CHAR_PLUS, 1'b0);
                    2:       add_char(CHAR_MINUS, 1'b0);
                    3:       add_char(CHAR_LPAREN, 1'b0);
                    4:       add_char(CHAR_RPAREN, 1'b0);
                    default: add_char(CHAR_NEWLINE, 1'b0);
                endcase
            end else if (piece < 86) begin
                add_char(($urandom_range(0, 2) != 0) ? CHAR_SPACE : CHAR_TAB, 1'b0);
            end else if (piece < 89) begin
                add_char(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                // noise: any byte, now and then with the end mark set
                add_char(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            end
        end
        // close whatever run is still open
        add_char(8'($urandom_range(0, 255)), 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        burst_left = 0;
        foreach (script[i]) begin
            if (burst_left == 0) begin
                burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
                                                         : $urandom_range(1, 40);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            in_valid     <= 1'b1;
            char_code    <= script[i].ch;
            end_of_input <= script[i].eoi;
            offered      <= script[i];
            do
                @(posedge clk);
            while (!in_ready);
            burst_left--;
        end
        in_valid <= 1'b0;

        // drain, then give a stray token time to show up
        while (pending_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (pending_tokens.size() != 0)
            $error("%0d tokens never arrived", pending_tokens.size());
        $display("covered %0d requests and %0d tokens (%0d keyword, %0d overlong)",
                 requests_taken, tokens_checked, keyword_tokens, overlong_tokens);
        $display("input held off for %0d cycles by a full output side", input_stall_cycles);
        if (mismatch_count == 0 && pending_tokens.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // receiver: phases of different ready patterns, plus one long hold-off
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int cycles;
        int style;
        int phase_len;
        logic held;
        cycles = 0;
        held   = 1'b0;
        wait (rst_n);
        forever begin
            style     = $urandom_range(0, 3);
            phase_len = $urandom_range(20, 120);
            repeat (phase_len) begin
                @(posedge clk);
                cycles++;
                // one long stall so the token queue fills and backs up the input
                if (!held && cycles >= HOLD_START) begin
                    held = 1'b1;
                    out_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (style)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= $urandom_range(0, 1) != 0;
                    2:       out_ready <= $urandom_range(0, 7) != 0;
                    default: out_ready <= $urandom_range(0, 3) == 0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // scoreboard: predict on every accepted request, check every token taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : scoreboard
        token_t step_toks [$];
        token_t want;
        if (rst_n) begin
            if (in_valid && !in_ready)
                input_stall_cycles++;
            if (in_valid && in_ready) begin
                requests_taken++;
                // the lexer always runs so its state follows typed rows too
                lex_step(char_code, end_of_input, step_toks);
                if (offered.typed) begin
                    pending_tokens.push_back(offered.tok0);
                    if (offered.count == 2'd2)
                        pending_tokens.push_back(offered.tok1);
                end else begin
                    foreach (step_toks[i])
                        pending_tokens.push_back(step_toks[i]);
                end
            end
            if (out_valid && out_ready) begin
                if (pending_tokens.size() == 0) begin
                    $error("token with nothing pending: kind %0d length %0d",
                           token_kind, token_length);
                    mismatch_count++;
                end else begin
                    want = pending_tokens.pop_front();
                    tokens_checked++;
                    if (want.kind == KIND_PRINT)
                        keyword_tokens++;
                    if (want.truncated)
                        overlong_tokens++;
                    if (token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
                        mismatch_count++;
                    end
                    if (token_length !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, token_length);
                        mismatch_count++;
                    end
                    if (truncated !== want.truncated) begin
                        $error("truncated: expected %0d, got %0d", want.truncated, truncated);
                        mismatch_count++;
                    end
                    if (last_of_item !== want.last) begin
                        $error("last_of_item: expected %0d, got %0d", want.last, last_of_item);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin : watchdog
        #500_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hdl/cst_pkg.sv
hdl/char_stream_tokenizer.sv
tb/char_stream_tokenizer_test.sv
